FILE: rtl/ddo_pkg.sv
package ddo_pkg;

   // field and datapath widths
   localparam int COUNT_WIDTH  = 16;
   localparam int COORD_WIDTH  = 32;
   localparam int ANGLE_WIDTH  = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   localparam int DPC_W       = 24;
   localparam int AXLE_W      = 20;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 104;

   localparam int MUL_W  = 64;
   localparam int PROD_W = 128;
   localparam int MAG_W  = 42;
   localparam int CORD_W = 34;
   localparam int CMAG_W = 63;
   localparam int SUM_W  = 64;
   localparam int BSQ_W  = 2 * AXLE_W;
   localparam int WQ_SHIFT = 72 - ANGLE_WIDTH;

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SHIFT  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_PER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXLE_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_LEFT    = 2'd2;

   localparam logic [DPC_W-1:0]  DPC_RESET  = 24'd65536;
   localparam logic [AXLE_W-1:0] AXLE_RESET = 20'd36045;

   // 2^64 / (2 pi)
   localparam logic [MUL_W-1:0] INV_TWO_PI_Q64 = 64'd2935890503282001226;
   localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032875;
   localparam logic signed [CORD_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [CORD_W-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic [CMAG_W-1:0] CHORD_LIMIT = 63'd1 << 62;

   localparam logic signed [SUM_W-1:0] COORD_MAX =
      {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] COORD_MIN = ~COORD_MAX;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_MUL_K, ST_DIV_T, ST_MUL_AD2, ST_MUL_CS, ST_DIV_C,
      ST_COR_H, ST_MUL_BS, ST_DIV_Q, ST_COR_T, ST_PROJ_X, ST_PROJ_Y, ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] value;
      logic                          sat;
   } sat_type;

   function automatic sat_type sat_coord(input logic signed [SUM_W-1:0] v);
      sat_type r;
      if (v > COORD_MAX) begin
         r.value = COORD_MAX[COORD_WIDTH-1:0];
         r.sat   = 1'b1;
      end else if (v < COORD_MIN) begin
         r.value = COORD_MIN[COORD_WIDTH-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = v[COORD_WIDTH-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/ddo_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ddo_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddo_pkg::MUL_W-1:0]   op_a,
   input  logic [ddo_pkg::MUL_W-1:0]   op_b,
   output logic [ddo_pkg::PROD_W-1:0]  product,
   output logic                        done
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(MUL_W);

   logic [MUL_W-1:0]  a_ff, b_ff, b_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W:0]    part;

   always_comb begin
      part    = {1'b0, acc_ff[PROD_W-1:MUL_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);
      acc_in  = acc_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         b_in    = op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {part, acc_ff[MUL_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      if (start) a_ff <= op_a;
      acc_ff <= acc_in;
      b_ff   <= b_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

FILE: rtl/ddo_div.sv
// restoring divider, one quotient bit per cycle; quotient shifts into the dividend
module ddo_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddo_pkg::PROD_W-1:0]  num,
   input  logic [ddo_pkg::MUL_W-1:0]   den,
   output logic [ddo_pkg::PROD_W-1:0]  quot,
   output logic                        done
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic [PROD_W-1:0] n_ff, n_in;
   logic [MUL_W-1:0]  rem_ff, rem_in, den_ff, rem_sh;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, ge;

   always_comb begin
      // remainder stays below the divisor (< 2^63), so the top bit drops out
      rem_sh  = {rem_ff[MUL_W-2:0], n_ff[PROD_W-1]};
      ge      = (rem_sh >= den_ff);
      n_in    = n_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = num;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[PROD_W-2:0], ge};
         rem_in = ge ? (rem_sh - den_ff) : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      if (start) den_ff <= den;
      n_ff   <= n_in;
      rem_ff <= rem_in;
   end

   assign quot = n_ff;
   assign done = done_ff;

endmodule

FILE: rtl/ddo_cordic.sv
// rotation-mode cordic, one micro-rotation per cycle
module ddo_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [31:0]                       angle,
   output logic signed [ddo_pkg::CORD_W-1:0] cos_out,
   output logic signed [ddo_pkg::CORD_W-1:0] sin_out,
   output logic                              done
);
   import ddo_pkg::*;

   logic signed [CORD_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, z0, xs, ys, at;
   logic [4:0] idx_ff, idx_in;
   logic       flip_ff, flip_in, busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      z0      = CORD_W'($signed(angle));
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      at      = $signed({2'b00, ATAN_TAB[idx_ff]});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      idx_in  = idx_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // fold into the right half-plane
         x_in   = CORDIC_START;
         y_in   = '0;
         idx_in = '0;
         busy_in = 1'b1;
         if (z0 > QUARTER_TURN) begin
            z_in = z0 - HALF_TURN;  flip_in = 1'b1;
         end else if (z0 < -QUARTER_TURN) begin
            z_in = z0 + HALF_TURN;  flip_in = 1'b1;
         end else begin
            z_in = z0;              flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[CORD_W-1]) begin
            x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + at;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == 5'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign done    = done_ff;

endmodule

FILE: rtl/diff_drive_odometry_top.sv
// Differential-drive odometry with exact-arc integration. Each request carries a kind on
// req_tuser: encoder update, set pose or shift position; every request gives one response
// with the pose (x, y in signed Q16.16 saturating, heading as a wrapping binary angle) and
// a flag set when a position clipped. Set and shift go straight from idle to the finish
// step and the response register. An encoder update walks a sequencer over a bit-serial
// multiplier (with start and done), a bit-serial divider and an iterative cordic; the
// serial divider and multiplier set how long a request takes, and a small turn runs one
// multiply more and one rotation less than a large turn. One request is in work at a time;
// a finished response may sit in the output register while the next request is accepted.
// Registers are written through csr_ only while the block is idle: the user must keep to
// this, the block itself does not enforce it; csr_ready is always high.
module diff_drive_odometry_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_counts, right_counts, pos_x, pos_y, pos_heading
   input  logic [ddo_pkg::REQ_DATA_W-1:0]      req_tdata,
   // func
   input  logic [ddo_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pose_x_out, pose_y_out, heading_out, saturated, zero padding
   output logic [ddo_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ddo_pkg::*;

   // control
   state_type state_ff, state_in;
   logic      issue_ff;
   logic      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // registers
   logic [DPC_W-1:0]  dpc_ff;
   logic [AXLE_W-1:0] axle_ff, b_eff;
   logic              inv_ff;

   // pose
   logic signed [COORD_WIDTH-1:0] pose_x_ff, pose_y_ff, nx_ff;
   logic [ANGLE_WIDTH-1:0]        heading_ff;
   logic                          sat_ff;

   // captured request
   logic [FUNC_W-1:0]             func_ff;
   logic signed [COUNT_WIDTH-1:0] left_ff, right_ff;
   logic signed [31:0]            posx_ff, posy_ff;
   logic [31:0]                   posh_ff;

   // work registers
   logic [MAG_W-1:0]  as_ff, ad_ff;
   logic              sneg_ff, dneg_ff, cneg_ff;
   logic [BSQ_W-1:0]  bsq_ff;
   logic [31:0]       hq_ff;
   logic [ANGLE_WIDTH-1:0] wq_ff;
   logic [CMAG_W-1:0] cmag_ff;

   // shared units
   logic              mul_start, mul_done, div_start, div_done, cor_start, cor_done;
   logic [MUL_W-1:0]  mul_a, mul_b, div_den;
   logic [PROD_W-1:0] mul_prod, div_quot;
   logic [31:0]       cor_angle;
   logic signed [CORD_W-1:0] cor_cos, cor_sin;

   // combinational datapath
   logic signed [MAG_W-1:0] dl_w, dr_w, dln_w, sum_w, dif_w;
   logic [CORD_W-1:0]  cos_mag, sin_mag;
   logic [51:0]        bs_w;
   logic [72:0]        hq_sum, wq_sum;
   logic [31:0]        hq_raw;
   logic [ANGLE_WIDTH-1:0] wq_raw;
   logic               small_w;
   logic [MUL_W-1:0]   small_den;
   logic [PROD_W:0]    q_round;
   logic               q_clamp;
   logic [95:0]        prj_round;
   logic signed [SUM_W-1:0] v_s, dx_w, dy_w;
   sat_type            sx, sy, set_x, set_y, sh_x, sh_y;
   logic signed [COORD_WIDTH-1:0] fin_x, fin_y;
   logic [ANGLE_WIDTH-1:0] fin_h;
   logic               fin_sat, fin_go;

   assign b_eff     = (axle_ff == '0) ? AXLE_W'(1) : axle_ff;
   assign csr_ready = 1'b1;

   // wheel distances in Q24
   assign dl_w  = left_ff * $signed({1'b0, dpc_ff});
   assign dr_w  = right_ff * $signed({1'b0, dpc_ff});
   assign dln_w = inv_ff ? -dl_w : dl_w;
   assign sum_w = dln_w + dr_w;
   assign dif_w = dln_w - dr_w;

   assign cos_mag = cor_cos[CORD_W-1] ? CORD_W'(-cor_cos) : CORD_W'(cor_cos);
   assign sin_mag = cor_sin[CORD_W-1] ? CORD_W'(-cor_sin) : CORD_W'(cor_sin);
   assign bs_w    = b_eff * sin_mag[31:0];

   // turn in Q72: heading step and half angle, both rounded half up
   assign hq_sum = div_quot[72:0] + (73'd1 << 40);
   assign wq_sum = div_quot[72:0] + (73'd1 << (WQ_SHIFT - 1));
   assign hq_raw = hq_sum[72:41];
   assign wq_raw = wq_sum[WQ_SHIFT+ANGLE_WIDTH-1:WQ_SHIFT];

   // small turn when 2|D| < b: series form of the chord
   assign small_w   = ({ad_ff, 1'b0} < (MAG_W+1)'(b_eff));
   assign small_den = (MUL_W'({bsq_ff, 4'b0}) + MUL_W'({bsq_ff, 3'b0})) << 16;

   // large turn: round to Q24 for 2c, clamp
   assign q_round = {1'b0, div_quot} + ((PROD_W+1)'(1) << 20);
   assign q_clamp = (|q_round[PROD_W:84]) || (q_round[83:21] > CHORD_LIMIT);

   // projection of the chord onto the axes, magnitude rounded half up at 2^39
   assign prj_round = mul_prod[95:0] + (96'd1 << 38);
   assign v_s  = $signed(SUM_W'(prj_round[95:39]));
   assign dx_w = (cneg_ff ^ cor_cos[CORD_W-1]) ? -v_s : v_s;
   assign dy_w = (cneg_ff ^ cor_sin[CORD_W-1]) ? v_s : -v_s;
   assign sx   = sat_coord(SUM_W'(pose_x_ff) + dx_w);
   assign sy   = sat_coord(SUM_W'(pose_y_ff) + dy_w);

   // set and shift
   assign set_x = sat_coord(SUM_W'(posx_ff));
   assign set_y = sat_coord(SUM_W'(posy_ff));
   assign sh_x  = sat_coord(SUM_W'(pose_x_ff) + SUM_W'(posx_ff));
   assign sh_y  = sat_coord(SUM_W'(pose_y_ff) + SUM_W'(posy_ff));

   always_comb begin
      fin_x = pose_x_ff;
      fin_y = pose_y_ff;
      fin_h = heading_ff;
      fin_sat = 1'b0;
      unique case (func_ff)
         FUNC_UPDATE: fin_sat = sat_ff;
         FUNC_SET: begin
            fin_x = set_x.value;
            fin_y = set_y.value;
            fin_h = posh_ff[ANGLE_WIDTH-1:0];
            fin_sat = set_x.sat | set_y.sat;
         end
         FUNC_SHIFT: begin
            fin_x = sh_x.value;
            fin_y = sh_y.value;
            fin_sat = sh_x.sat | sh_y.sat;
         end
         default: fin_sat = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      cor_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      div_den    = MUL_W'(b_eff);
      cor_angle  = hq_ff;
      fin_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid)
               state_in = (req_tuser == FUNC_UPDATE) ? ST_PROD : ST_FINISH;
         end
         ST_PROD: state_in = ST_MUL_K;
         ST_MUL_K: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(ad_ff);
            mul_b = INV_TWO_PI_Q64;
            if (mul_done) state_in = ST_DIV_T;
         end
         ST_DIV_T: begin
            div_start = issue_ff;
            div_den = MUL_W'(b_eff);
            if (div_done) state_in = small_w ? ST_MUL_AD2 : ST_COR_H;
         end
         ST_MUL_AD2: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(ad_ff);
            mul_b = MUL_W'(ad_ff);
            if (mul_done) state_in = ST_MUL_CS;
         end
         ST_MUL_CS: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(as_ff);
            mul_b = mul_prod[MUL_W-1:0];
            if (mul_done) state_in = ST_DIV_C;
         end
         ST_DIV_C: begin
            div_start = issue_ff;
            div_den = small_den;
            if (div_done) state_in = ST_COR_T;
         end
         ST_COR_H: begin
            cor_start = issue_ff;
            cor_angle = hq_ff;
            if (cor_done) state_in = ST_MUL_BS;
         end
         ST_MUL_BS: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(bs_w);
            mul_b = MUL_W'(as_ff);
            if (mul_done) state_in = ST_DIV_Q;
         end
         ST_DIV_Q: begin
            div_start = issue_ff;
            div_den = MUL_W'(ad_ff);
            if (div_done) state_in = ST_COR_T;
         end
         ST_COR_T: begin
            cor_start = issue_ff;
            cor_angle = (32'(heading_ff) << (32 - ANGLE_WIDTH)) + hq_ff;
            if (cor_done) state_in = ST_PROJ_X;
         end
         ST_PROJ_X: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(cmag_ff);
            mul_b = MUL_W'(cos_mag);
            if (mul_done) state_in = ST_PROJ_Y;
         end
         ST_PROJ_Y: begin
            mul_start = issue_ff;
            mul_a = MUL_W'(cmag_ff);
            mul_b = MUL_W'(sin_mag);
            if (mul_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               fin_go   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         dpc_ff        <= DPC_RESET;
         axle_ff       <= AXLE_RESET;
         inv_ff        <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         heading_ff    <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= (state_in != state_ff);
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DIST_PER_COUNT: dpc_ff  <= csr_wdata[DPC_W-1:0];
               CSR_AXLE_WIDTH:     axle_ff <= csr_wdata[AXLE_W-1:0];
               CSR_INVERT_LEFT:    inv_ff  <= csr_wdata[0];
               default:            inv_ff  <= inv_ff;
            endcase
         end
         if (state_ff == ST_PROJ_Y && mul_done) begin
            pose_x_ff  <= nx_ff;
            pose_y_ff  <= sy.value;
            heading_ff <= heading_ff + wq_ff;
         end
         if (fin_go) begin
            pose_x_ff     <= fin_x;
            pose_y_ff     <= fin_y;
            heading_ff    <= fin_h;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff  <= req_tuser;
         left_ff  <= req_tdata[15:0];
         right_ff <= req_tdata[31:16];
         posx_ff  <= req_tdata[63:32];
         posy_ff  <= req_tdata[95:64];
         posh_ff  <= req_tdata[127:96];
      end
      if (state_ff == ST_PROD) begin
         as_ff   <= sum_w[MAG_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
         ad_ff   <= dif_w[MAG_W-1] ? MAG_W'(-dif_w) : MAG_W'(dif_w);
         sneg_ff <= sum_w[MAG_W-1];
         dneg_ff <= dif_w[MAG_W-1];
         bsq_ff  <= b_eff * b_eff;
      end
      if (state_ff == ST_DIV_T && div_done) begin
         hq_ff   <= dneg_ff ? (32'd0 - hq_raw) : hq_raw;
         wq_ff   <= dneg_ff ? (ANGLE_WIDTH'(0) - wq_raw) : wq_raw;
         cneg_ff <= sneg_ff;
      end
      if (state_ff == ST_DIV_C && div_done)
         cmag_ff <= CMAG_W'(MUL_W'(as_ff) - div_quot[MUL_W-1:0]);
      if (state_ff == ST_COR_H && cor_done)
         cneg_ff <= cneg_ff ^ cor_sin[CORD_W-1] ^ dneg_ff;
      if (state_ff == ST_DIV_Q && div_done)
         cmag_ff <= q_clamp ? CHORD_LIMIT : q_round[83:21];
      if (state_ff == ST_PROJ_X && mul_done) begin
         nx_ff  <= sx.value;
         sat_ff <= sx.sat;
      end
      if (state_ff == ST_PROJ_Y && mul_done)
         sat_ff <= sat_ff | sy.sat;
      if (fin_go)
         rsp_data_ff <= {7'd0, fin_sat, 32'(fin_h), 32'(fin_y), 32'(fin_x)};
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ddo_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(mul_a), .op_b(mul_b), .product(mul_prod), .done(mul_done)
   );

   ddo_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(mul_prod), .den(div_den), .quot(div_quot), .done(div_done)
   );

   ddo_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(cor_angle),
      .cos_out(cor_cos), .sin_out(cor_sin), .done(cor_done)
   );

   // a unit only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_K || state_ff == ST_MUL_AD2 || state_ff == ST_MUL_CS ||
                    state_ff == ST_MUL_BS || state_ff == ST_PROJ_X || state_ff == ST_PROJ_Y))
      else $error("multiplier finished outside a multiply step");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_T || state_ff == ST_DIV_C || state_ff == ST_DIV_Q))
      else $error("divider finished outside a divide step");

   assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_COR_H || state_ff == ST_COR_T))
      else $error("cordic finished outside a rotation step");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted request left no work");

endmodule

FILE: sim/diff_drive_odometry_top_test.sv
module diff_drive_odometry_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ddo_pkg::*;

   // kind code the block leaves unused: pose reported unchanged
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int          CYCLE_LIMIT   = 4000000;
   localparam int          DRAIN_CYCLES  = 1000;
   localparam logic [63:0] CHORD_CAP     = 64'd1 << 62;
   localparam logic [63:0] INV_TWO_PI    = 64'd2935890503282001226;

   typedef struct {
      logic [FUNC_W-1:0] kind;
      logic [15:0]       lc;
      logic [15:0]       rc;
      logic [31:0]       px;
      logic [31:0]       py;
      logic [31:0]       ph;
   } pose_req_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] hdg;
      logic        sat;
   } pose_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   diff_drive_odometry_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // pending requests, filled phase by phase, and the poses still owed
   pose_req_type pending_reqs[$];
   pose_rsp_type owed_poses[$];

   // shadow of the block: registers and pose
   logic [23:0] dist_per_count = DPC_RESET;
   logic [19:0] axle = AXLE_RESET;
   logic        inv_left = 1'b0;
   longint      trk_x = 0;
   longint      trk_y = 0;
   logic [31:0] trk_hdg = '0;

   int  fails = 0;
   int  cycles = 0;
   int  phase_no = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   bit  no_idle = 1'b0;
   bit  hold_rsp = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      fails++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // rotation-mode cordic, quadrant fold by half a turn, Q30 outputs
   task automatic cordic_rot(input logic [31:0] ang, output longint cs, output longint sn);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'($signed(ang));
      x = 652032875;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= longint'(ATAN_TAB[i]);
         end else begin
            x += ys;
            y -= xs;
            z += longint'(ATAN_TAB[i]);
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // signed chord component: magnitude rounded half up at 2^39, sign applied after
   function automatic longint project(input logic [63:0] cm, input bit cn, input longint tv);
      logic [127:0] p;
      longint v;
      p = ({64'd0, cm} * {64'd0, magnitude(tv)} + (128'd1 << 38)) >> 39;
      v = longint'(p[63:0]);
      return (cn != (tv < 0)) ? -v : v;
   endfunction

   function automatic longint clip_add(input longint a, input longint b, inout bit sat);
      longint r;
      r = a + b;
      if (r > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return r;
   endfunction

   // advances the shadow pose by one request and returns the pose the block must report
   task automatic advance_pose(input pose_req_type rq, output pose_rsp_type rs);
      longint dl, dr, sum, dif, cc, ss, mx, my;
      logic [63:0] as_m, ad_m, b, cmag;
      logic [127:0] turn, corr, q;
      logic [31:0] hq, wq;
      bit cneg, sat;
      sat = 1'b0;
      case (rq.kind)
         FUNC_UPDATE: begin
            dl = longint'($signed(rq.lc)) * longint'({40'd0, dist_per_count});
            dr = longint'($signed(rq.rc)) * longint'({40'd0, dist_per_count});
            if (inv_left) dl = -dl;
            sum = dl + dr;
            dif = dl - dr;
            as_m = magnitude(sum);
            ad_m = magnitude(dif);
            b = (axle == 0) ? 64'd1 : {44'd0, axle};
            turn = ({64'd0, ad_m} * {64'd0, INV_TWO_PI}) / {64'd0, b};
            hq = 32'((turn + (128'd1 << 40)) >> 41);
            wq = 32'((turn + (128'd1 << 39)) >> 40);
            if (dif < 0) begin
               hq = -hq;
               wq = -wq;
            end
            cneg = sum < 0;
            if (2 * ad_m < b) begin
               // small turn: series form of the chord
               corr = ({64'd0, as_m} * {64'd0, ad_m * ad_m}) /
                      ({64'd0, 24 * b * b} << 16);
               cmag = as_m - corr[63:0];
            end else begin
               cordic_rot(hq, cc, ss);
               if (ss < 0) cneg = !cneg;
               if (dif < 0) cneg = !cneg;
               q = ({64'd0, b * magnitude(ss)} * {64'd0, as_m}) / {64'd0, ad_m};
               q = (q + (128'd1 << 20)) >> 21;
               cmag = (q > {64'd0, CHORD_CAP}) ? CHORD_CAP : q[63:0];
            end
            cordic_rot(trk_hdg + hq, cc, ss);
            mx = project(cmag, cneg, cc);
            my = project(cmag, cneg, ss);
            trk_x = clip_add(trk_x, mx, sat);
            trk_y = clip_add(trk_y, -my, sat);
            trk_hdg = trk_hdg + wq;
         end
         FUNC_SET: begin
            trk_x = clip_add(0, longint'($signed(rq.px)), sat);
            trk_y = clip_add(0, longint'($signed(rq.py)), sat);
            trk_hdg = rq.ph;
         end
         FUNC_SHIFT: begin
            trk_x = clip_add(trk_x, longint'($signed(rq.px)), sat);
            trk_y = clip_add(trk_y, longint'($signed(rq.py)), sat);
         end
         default: ;
      endcase
      rs.x = trk_x[31:0];
      rs.y = trk_y[31:0];
      rs.hdg = trk_hdg;
      rs.sat = sat;
   endtask

   // request driver; prediction happens on acceptance
   always @(posedge clock) begin
      pose_req_type nxt, took;
      pose_rsp_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            took.lc = req_tdata[15:0];
            took.rc = req_tdata[31:16];
            took.px = req_tdata[63:32];
            took.py = req_tdata[95:64];
            took.ph = req_tdata[127:96];
            took.kind = req_tuser;
            advance_pose(took, want);
            owed_poses.push_back(want);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_tdata <= {nxt.ph, nxt.py, nxt.px, nxt.rc, nxt.lc};
               req_tuser <= nxt.kind;
               req_tvalid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      pose_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_poses.size() == 0) begin
               report("response with nothing owed", rsp_tdata[31:0], 32'd0);
            end else begin
               want = owed_poses.pop_front();
               if (rsp_tdata[31:0] !== want.x) report("pose_x", rsp_tdata[31:0], want.x);
               if (rsp_tdata[63:32] !== want.y) report("pose_y", rsp_tdata[63:32], want.y);
               if (rsp_tdata[95:64] !== want.hdg)
                  report("heading", rsp_tdata[95:64], want.hdg);
               if (rsp_tdata[96] !== want.sat)
                  report("saturated", {31'd0, rsp_tdata[96]}, {31'd0, want.sat});
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= pick_gap();
         end
      end
   end

   // long receiver hold-off early in the random part: fills the block and stalls requests
   initial begin
      wait (phase_no == 5);
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (6000) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic add_req(input logic [FUNC_W-1:0] kind, input logic [15:0] lc,
                          input logic [15:0] rc, input logic [31:0] px,
                          input logic [31:0] py, input logic [31:0] ph);
      pose_req_type rq;
      rq.kind = kind;
      rq.lc = lc;
      rq.rc = rc;
      rq.px = px;
      rq.py = py;
      rq.ph = ph;
      pending_reqs.push_back(rq);
   endtask

   function automatic logic [15:0] rand_count();
      int m;
      m = $urandom_range(0, 9);
      if (m < 5) return 16'($urandom_range(0, 400) - 200);
      if (m < 8) return 16'($urandom);
      if (m == 8) return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
      return 16'd0;
   endfunction

   function automatic logic [31:0] rand_coord();
      int m;
      m = $urandom_range(0, 9);
      if (m < 6) return 32'($urandom_range(0, 2 << 20) - (1 << 20));
      if (m < 9) return $urandom;
      return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
   endfunction

   // random part: mostly encoder updates, with the odd set, shift and unused kind
   task automatic add_random(input int n);
      int r;
      logic [15:0] c;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         c = rand_count();
         if (r < 40)
            add_req(FUNC_UPDATE, rand_count(), rand_count(), $urandom, $urandom, $urandom);
         else if (r < 50)
            add_req(FUNC_UPDATE, c, c, $urandom, $urandom, $urandom);     // straight
         else if (r < 58)
            add_req(FUNC_UPDATE, c, -c, $urandom, $urandom, $urandom);    // spin
         else if (r < 76)
            add_req(FUNC_SHIFT, 16'($urandom), 16'($urandom), rand_coord(), rand_coord(),
                    $urandom);
         else if (r < 94)
            add_req(FUNC_SET, 16'($urandom), 16'($urandom), rand_coord(), rand_coord(),
                    $urandom);
         else
            add_req(FUNC_UNUSED, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      end
   endtask

   // lets the phase run out: all requests taken, every pose back, block settled
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || owed_poses.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      case (idx)
         CSR_DIST_PER_COUNT: dist_per_count = val;
         CSR_AXLE_WIDTH:     axle = val[19:0];
         CSR_INVERT_LEFT:    inv_left = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [23:0] dpc, input logic [19:0] ax, input bit inv);
      @(posedge clock);
      csr_write(CSR_DIST_PER_COUNT, dpc);
      csr_write(CSR_AXLE_WIDTH, {4'd0, ax});
      csr_write(CSR_INVERT_LEFT, {23'd0, inv});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 0: reset registers, extremes of counts, every kind
      phase_no = 0;
      no_idle = 1'b1;
      add_req(FUNC_UPDATE, 16'd0, 16'd0, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'd100, 16'd100, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h7fff, 16'h7fff, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h8000, 16'h8000, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'd1, 16'hffff, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h7fff, 16'h8000, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h8000, 16'h7fff, '0, '0, '0);
      add_req(FUNC_SET, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      add_req(FUNC_SHIFT, '0, '0, 32'd1, 32'hffff_ffff, '0);          // clips both ways
      add_req(FUNC_UPDATE, 16'd500, 16'd300, '0, '0, '0);
      add_req(FUNC_SET, '0, '0, '0, '0, '0);                          // pose reset
      add_req(FUNC_UNUSED, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      add_req(FUNC_SHIFT, '0, '0, 32'h8000_0000, 32'h7fff_ffff, '0);
      add_req(FUNC_SHIFT, '0, '0, 32'h8000_0000, 32'h7fff_ffff, '0);
      drain();

      // phase 1: tiny steps on a wide axle, left inverted: small-turn chord
      phase_no = 1;
      no_idle = 1'b0;
      configure(24'd1, 20'hfffff, 1'b1);
      add_req(FUNC_UPDATE, 16'd1, 16'd0, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'd100, 16'hffce, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h8000, 16'h7fff, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h7fff, 16'h7fff, '0, '0, '0);
      add_random(20);
      drain();

      // phase 2: no distance per count, zero axle width
      phase_no = 2;
      configure(24'd0, 20'd0, 1'b0);
      add_req(FUNC_UPDATE, 16'h7fff, 16'h8000, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'd40, 16'd7, '0, '0, '0);
      add_random(10);
      drain();

      // phase 3: largest distance per count, narrowest axle
      phase_no = 3;
      configure(24'hffffff, 20'd1, 1'b1);
      add_req(FUNC_SET, '0, '0, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h7fff, 16'h8000, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'h8000, 16'h8000, '0, '0, '0);
      add_req(FUNC_UPDATE, 16'd3, 16'd1, '0, '0, '0);
      add_random(20);
      drain();

      // phase 4: zero axle again with motion
      phase_no = 4;
      configure(24'd65536, 20'd0, 1'b0);
      add_random(20);
      drain();

      // random phases, each under its own register setting
      for (int p = 0; p < 4; p++) begin
         case ($urandom_range(0, 3))
            0: configure(24'($urandom_range(1, 4096)), 20'($urandom), 1'($urandom));
            1: configure(24'($urandom_range(30000, 100000)), 20'($urandom_range(20000, 60000)),
                         1'($urandom));
            2: configure(24'hffffff, 20'($urandom_range(1, 1048575)), 1'($urandom));
            default: configure(24'($urandom), 20'($urandom), 1'($urandom));
         endcase
         phase_no = 5 + p;
         no_idle = (p == 2);
         add_random(150);
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
